// ===== hdl/axis_homing_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// axis homing sequencer assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef AXIS_HOMING_SEQUENCER_MACROS_SVH
`define AXIS_HOMING_SEQUENCER_MACROS_SVH

// property checked on every rising clock edge outside reset
`define AHS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("axis homing sequencer check failed");

// antecedent in this cycle implies consequent in the next
`define AHS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("axis homing sequencer sequence check failed");

`endif

// ===== hdl/ahs_pkg.sv =====
// ----------------------------------------------------------------------------
// ahs_pkg
// codes, constants and types of the axis homing sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package ahs_pkg;

  localparam int CMD_W   = 3;
  localparam int SPEED_W = 16;
  localparam int ACCEL_W = 8;
  localparam int STEP_W  = 4;
  localparam int COUNT_W = 16;
  localparam int INDEX_W = 8;

  // motion command codes
  localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_AWAY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TOWARD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CREEP  = 3'd4;

  // sequence steps
  localparam logic [STEP_W-1:0] STEP_IDLE       = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK      = 4'd1;
  localparam logic [STEP_W-1:0] STEP_APPROACH   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SEEK       = 4'd3;
  localparam logic [STEP_W-1:0] STEP_WAIT_STOP  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CREEP      = 4'd5;
  localparam logic [STEP_W-1:0] STEP_CREEP_DONE = 4'd6;
  localparam logic [STEP_W-1:0] STEP_BACKOFF    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RELEASE    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_SETTLE     = 4'd9;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_APPROACH_SPEED = 8'd0;
  localparam logic [INDEX_W-1:0] REG_SETTLE_TICKS   = 8'd1;

  // motion profile constants
  localparam logic [SPEED_W-1:0] BACKOFF_SPEED  = 16'd1;
  localparam logic [ACCEL_W-1:0] BACKOFF_ACCEL  = 8'd50;
  localparam logic [ACCEL_W-1:0] APPROACH_ACCEL = 8'd150;
  localparam logic [SPEED_W-1:0] CREEP_SPEED    = 16'd3;

  // register reset values
  localparam logic [SPEED_W-1:0] APPROACH_RESET = 16'd10;
  localparam logic [COUNT_W-1:0] SETTLE_RESET   = 16'd500;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SPEED_W-1:0] speed;
    logic [ACCEL_W-1:0] accel;
    logic               active;
    logic               clear;
    logic [STEP_W-1:0]  step;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/ahs_core.sv =====
// ----------------------------------------------------------------------------
// ahs_core
// step register, settle counter and per-tick command decode
// ----------------------------------------------------------------------------
`default_nettype none

module ahs_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire logic                       start,
  input  wire logic                       home,
  input  wire logic                       busy,
  input  wire logic [ahs_pkg::SPEED_W-1:0] approach_speed,
  input  wire logic [ahs_pkg::COUNT_W-1:0] settle_ticks,
  output ahs_pkg::res_t                   res
);
  import ahs_pkg::*;

  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  logic [COUNT_W-1:0] settle_count;
  logic [COUNT_W-1:0] settle_count_next;
  logic [CMD_W-1:0]   cmd;
  logic [SPEED_W-1:0] spd;
  logic [ACCEL_W-1:0] acc;
  logic               clr;

  always_comb begin
    step_next         = step;
    settle_count_next = settle_count;
    cmd               = CMD_NONE;
    spd               = '0;
    acc               = '0;
    clr               = 1'b0;
    unique case (step)
      STEP_IDLE: begin
        if (start) step_next = STEP_CHECK;
      end
      STEP_CHECK: begin
        if (home) begin
          step_next = STEP_RELEASE;
          cmd       = CMD_AWAY;
          spd       = BACKOFF_SPEED;
          acc       = BACKOFF_ACCEL;
        end else begin
          step_next = STEP_APPROACH;
        end
      end
      STEP_APPROACH: begin
        if (!busy) begin
          step_next = STEP_SEEK;
          cmd       = CMD_TOWARD;
          spd       = approach_speed;
          acc       = APPROACH_ACCEL;
        end
      end
      STEP_SEEK: begin
        if (home) begin
          step_next = STEP_BACKOFF;
          cmd       = CMD_STOP;
        end
      end
      STEP_WAIT_STOP: begin
        if (!busy) step_next = STEP_CREEP;
      end
      STEP_CREEP: begin
        if (!busy) begin
          step_next = STEP_CREEP_DONE;
          cmd       = CMD_CREEP;
          spd       = CREEP_SPEED;
        end
      end
      STEP_CREEP_DONE: begin
        if (!busy) begin
          step_next         = STEP_SETTLE;
          settle_count_next = settle_ticks;
        end
      end
      STEP_BACKOFF: begin
        if (!busy) begin
          step_next = STEP_RELEASE;
          cmd       = CMD_AWAY;
          spd       = BACKOFF_SPEED;
          acc       = BACKOFF_ACCEL;
        end
      end
      STEP_RELEASE: begin
        if (!home) begin
          step_next = STEP_WAIT_STOP;
          cmd       = CMD_STOP;
        end
      end
      STEP_SETTLE: begin
        if (settle_count == '0) begin
          step_next = STEP_IDLE;
          clr       = 1'b1;
        end else begin
          settle_count_next = settle_count - 1'b1;
        end
      end
      // unused step codes fall back to idle
      default: step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= STEP_IDLE;
      settle_count <= '0;
    end else if (advance) begin
      step         <= step_next;
      settle_count <= settle_count_next;
    end
  end

  always_comb begin
    res.command = cmd;
    res.speed   = spd;
    res.accel   = acc;
    res.active  = (step_next != STEP_IDLE);
    res.clear   = clr;
    res.step    = step_next;
  end

endmodule

`default_nettype wire

// ===== hdl/axis_homing_sequencer.sv =====
// ----------------------------------------------------------------------------
// axis_homing_sequencer
// homing sequence controller for one stepper axis, one tick per beat
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one tick per beat: start
//   request, home switch level and motion busy flag
//   output channel (out_valid / out_stall) returns exactly one result beat
//   per tick: command code with speed and accel, homing_active,
//   clear_encoder pulse and the step reached after the tick
//   config channel (cfg_valid / cfg_ready) writes approach_speed (index 0)
//   or settle_ticks (index 1); other indexes are dropped; always ready
// timing:
//   a beat lands in the input register, the step logic decodes it
//   combinationally and the result register is loaded from it once the
//   result beat ahead of it is no longer stalled
//   one tick per cycle is sustained unless a result beat is stalled; the step
//   and settle registers update once per tick as it enters the result register
// reset: sequencer goes idle, settle count clears, approach_speed = 10,
//   settle_ticks = 500, both channels empty
// stall: a held result keeps the input register full; in_stall rises only
//   when the input register holds a beat and the result beat is stalled
// ----------------------------------------------------------------------------
`default_nettype none

module axis_homing_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // tick input
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        start_request,
  input  wire logic                        home_switch,
  input  wire logic                        motion_busy,
  // result output
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ahs_pkg::CMD_W-1:0]        command,
  output logic [ahs_pkg::SPEED_W-1:0]      command_speed,
  output logic [ahs_pkg::ACCEL_W-1:0]      command_accel,
  output logic                             homing_active,
  output logic                             clear_encoder,
  output logic [ahs_pkg::STEP_W-1:0]       step_now,
  // register writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ahs_pkg::INDEX_W-1:0] cfg_index,
  input  wire logic [ahs_pkg::SPEED_W-1:0] cfg_data
);
  import ahs_pkg::*;

  // input register
  logic s1_valid;
  logic s1_start;
  logic s1_home;
  logic s1_busy;

  // configuration registers
  logic [SPEED_W-1:0] approach_speed;
  logic [COUNT_W-1:0] settle_ticks;

  logic in_take;
  logic out_free;
  logic advance;
  res_t res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // config writes, out-of-range indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      approach_speed <= APPROACH_RESET;
      settle_ticks   <= SETTLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_APPROACH_SPEED: approach_speed <= cfg_data;
        REG_SETTLE_TICKS:   settle_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: holds one tick until the result register can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_start <= start_request;
      s1_home  <= home_switch;
      s1_busy  <= motion_busy;
    end
  end

  ahs_core u_core (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .start          (s1_start),
    .home           (s1_home),
    .busy           (s1_busy),
    .approach_speed (approach_speed),
    .settle_ticks   (settle_ticks),
    .res            (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      command       <= res.command;
      command_speed <= res.speed;
      command_accel <= res.accel;
      homing_active <= res.active;
      clear_encoder <= res.clear;
      step_now      <= res.step;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ahs_checker.sv =====
// ----------------------------------------------------------------------------
// ahs_checker
// port-level checks on the axis homing sequencer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "axis_homing_sequencer_macros.svh"

module ahs_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic                        start_request,
  input  wire logic                        home_switch,
  input  wire logic                        motion_busy,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [ahs_pkg::CMD_W-1:0]   command,
  input  wire logic [ahs_pkg::SPEED_W-1:0] command_speed,
  input  wire logic [ahs_pkg::ACCEL_W-1:0] command_accel,
  input  wire logic                        homing_active,
  input  wire logic                        clear_encoder,
  input  wire logic [ahs_pkg::STEP_W-1:0]  step_now
);
  import ahs_pkg::*;

  // active flag follows the step
  `AHS_ASSERT(a_active_step, clk, rst,
    !out_valid || (homing_active == (step_now != STEP_IDLE)))

  // encoder clear only as the sequence returns to idle
  `AHS_ASSERT(a_clear_idle, clk, rst,
    !(out_valid && clear_encoder) || (step_now == STEP_IDLE && command == CMD_NONE))

  // no command means no speed and no accel
  `AHS_ASSERT(a_none_quiet, clk, rst,
    !(out_valid && command == CMD_NONE) || (command_speed == '0 && command_accel == '0))

  // a stalled result beat holds
  `AHS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(command) && $stable(step_now) && $stable(clear_encoder))

  // a stalled tick beat holds
  `AHS_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall,
    in_valid && $stable(start_request) && $stable(home_switch) && $stable(motion_busy))

endmodule

bind axis_homing_sequencer ahs_checker u_ahs_checker (.*);

`default_nettype wire

// ===== bench/axis_homing_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// axis_homing_sequencer_tb
// self-checking bench for the one-axis homing sequencer: ticks are planned
// so that most runs walk the whole homing sequence, and every result beat is
// compared field by field against a cycle-free predictor of the step logic
// ----------------------------------------------------------------------------
`default_nettype none

module axis_homing_sequencer_tb;
  import ahs_pkg::*;

  // one tick as it travels on the input channel
  typedef struct packed {
    logic start;
    logic home;
    logic busy;
  } tick_t;

  // sequencer state as the predictor sees it
  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [COUNT_W-1:0] count;
  } seq_state_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                start_request = 1'b0;
  logic                home_switch = 1'b0;
  logic                motion_busy = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CMD_W-1:0]    command;
  logic [SPEED_W-1:0]  command_speed;
  logic [ACCEL_W-1:0]  command_accel;
  logic                homing_active;
  logic                clear_encoder;
  logic [STEP_W-1:0]   step_now;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [INDEX_W-1:0]  cfg_index = '0;
  logic [SPEED_W-1:0]  cfg_data = '0;

  // register copies, written only while nothing is in flight
  logic [SPEED_W-1:0]  approach_cfg = APPROACH_RESET;
  logic [COUNT_W-1:0]  settle_cfg = SETTLE_RESET;

  // planner state advances as ticks are queued, live state as they are taken
  seq_state_t          seq_plan = '0;
  seq_state_t          seq_live = '0;
  seq_state_t          seq_after;
  tick_t               tick_live;
  logic                tick_held = 1'b0;
  res_t                predicted;
  res_t                want;

  tick_t               tick_backlog[$];
  res_t                pending_results[$];

  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  fail_count = 0;
  int                  ticks_taken = 0;
  int                  results_checked = 0;
  int                  clears_seen = 0;
  int                  reg_writes = 0;

  axis_homing_sequencer uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .start_request (start_request),
    .home_switch   (home_switch),
    .motion_busy   (motion_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command       (command),
    .command_speed (command_speed),
    .command_accel (command_accel),
    .homing_active (homing_active),
    .clear_encoder (clear_encoder),
    .step_now      (step_now),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case a beat never comes back
  initial begin
    #20000000;
    $display("axis_homing_sequencer: mismatch");
    $finish;
  end

  // one tick of the homing step logic: returns the result beat and the next state
  function automatic res_t next_homing_step(input seq_state_t cur, input tick_t t,
                                            input logic [SPEED_W-1:0] appr,
                                            input logic [COUNT_W-1:0] settle,
                                            output seq_state_t nxt);
    res_t r;
    r = '0;
    r.command = CMD_NONE;
    nxt = cur;
    case (cur.step)
      STEP_IDLE: begin
        if (t.start) nxt.step = STEP_CHECK;
      end
      STEP_CHECK: begin
        // already sitting on the switch: skip the approach, back off right away
        if (t.home) begin
          nxt.step = STEP_RELEASE;
          r.command = CMD_AWAY;
          r.speed = BACKOFF_SPEED;
          r.accel = BACKOFF_ACCEL;
        end else begin
          nxt.step = STEP_APPROACH;
        end
      end
      STEP_APPROACH: begin
        if (!t.busy) begin
          nxt.step = STEP_SEEK;
          r.command = CMD_TOWARD;
          r.speed = appr;
          r.accel = APPROACH_ACCEL;
        end
      end
      STEP_SEEK: begin
        if (t.home) begin
          nxt.step = STEP_BACKOFF;
          r.command = CMD_STOP;
        end
      end
      STEP_WAIT_STOP: begin
        if (!t.busy) nxt.step = STEP_CREEP;
      end
      STEP_CREEP: begin
        if (!t.busy) begin
          nxt.step = STEP_CREEP_DONE;
          r.command = CMD_CREEP;
          r.speed = CREEP_SPEED;
        end
      end
      STEP_CREEP_DONE: begin
        if (!t.busy) begin
          nxt.step = STEP_SETTLE;
          nxt.count = settle;
        end
      end
      STEP_BACKOFF: begin
        if (!t.busy) begin
          nxt.step = STEP_RELEASE;
          r.command = CMD_AWAY;
          r.speed = BACKOFF_SPEED;
          r.accel = BACKOFF_ACCEL;
        end
      end
      STEP_RELEASE: begin
        if (!t.home) begin
          nxt.step = STEP_WAIT_STOP;
          r.command = CMD_STOP;
        end
      end
      STEP_SETTLE: begin
        // the tick that finds the count at zero ends the sequence
        if (cur.count == '0) begin
          nxt.step = STEP_IDLE;
          r.clear = 1'b1;
        end else begin
          nxt.count = cur.count - 1'b1;
        end
      end
      default: begin
        nxt.step = STEP_IDLE;
      end
    endcase
    r.active = (nxt.step != STEP_IDLE);
    r.step = nxt.step;
    return r;
  endfunction

  // pick tick contents that fit the planned step most of the time
  function automatic tick_t plan_tick(input logic [STEP_W-1:0] step);
    tick_t t;
    t.start = 1'($urandom_range(1));
    t.home = 1'($urandom_range(1));
    t.busy = 1'($urandom_range(1));
    // one tick in ten is left as pure noise
    if ($urandom_range(9) != 0) begin
      case (step)
        STEP_IDLE: t.start = ($urandom_range(3) == 0);
        STEP_APPROACH: begin
          t.home = 1'b0;
          t.busy = ($urandom_range(9) < 6);
        end
        STEP_SEEK: begin
          t.home = ($urandom_range(4) == 0);
          t.busy = 1'b1;
        end
        STEP_BACKOFF: begin
          t.home = 1'b1;
          t.busy = ($urandom_range(9) < 6);
        end
        STEP_RELEASE: begin
          t.home = ($urandom_range(4) != 0);
          t.busy = 1'b1;
        end
        STEP_WAIT_STOP, STEP_CREEP, STEP_CREEP_DONE: begin
          t.busy = ($urandom_range(9) < 6);
        end
        default: ;
      endcase
    end
    return t;
  endfunction

  task automatic push_tick(input logic s, input logic h, input logic b);
    tick_t t;
    res_t unused;
    seq_state_t nxt;
    t.start = s;
    t.home = h;
    t.busy = b;
    tick_backlog.push_back(t);
    unused = next_homing_step(seq_plan, t, approach_cfg, settle_cfg, nxt);
    seq_plan = nxt;
  endtask

  // queue planned ticks, then keep going until the planner is back at idle
  task automatic queue_sequences(input int budget);
    tick_t t;
    int n;
    n = 0;
    while (n < budget || seq_plan.step != STEP_IDLE) begin
      t = plan_tick(seq_plan.step);
      push_tick(t.start, t.home, t.busy);
      n++;
    end
  endtask

  // wait until every queued tick has been taken and every result returned
  task automatic wait_drained();
    while (tick_backlog.size() != 0 || tick_held || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write on the config channel; called just after a rising edge
  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [SPEED_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    // writes to unknown indexes are dropped by the block
    if (idx == REG_APPROACH_SPEED) approach_cfg = val;
    else if (idx == REG_SETTLE_TICKS) settle_cfg = val;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [SPEED_W-1:0] exp_val,
                             input logic [SPEED_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // tick driver: hold a beat until taken, then maybe load the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = next_homing_step(seq_live, tick_live, approach_cfg, settle_cfg, seq_after);
        seq_live = seq_after;
        pending_results.push_back(predicted);
        tick_held = 1'b0;
        ticks_taken++;
      end
      if (!tick_held && tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        tick_live = tick_backlog.pop_front();
        tick_held = 1'b1;
        in_valid <= 1'b1;
        start_request <= tick_live.start;
        home_switch <= tick_live.home;
        motion_busy <= tick_live.busy;
      end else if (!tick_held) begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: compare each taken beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, step %0d", $time, step_now);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("command", SPEED_W'(want.command), SPEED_W'(command));
          check_field("command_speed", want.speed, command_speed);
          check_field("command_accel", SPEED_W'(want.accel), SPEED_W'(command_accel));
          check_field("homing_active", SPEED_W'(want.active), SPEED_W'(homing_active));
          check_field("clear_encoder", SPEED_W'(want.clear), SPEED_W'(clear_encoder));
          check_field("step_now", SPEED_W'(want.step), SPEED_W'(step_now));
          if (want.clear) clears_seen++;
          results_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles rarely, receiver stalls a lot
    send_idle_pct = 9;
    recv_idle_pct = 68;

    // reset register values: full sequence starting off the switch, with the
    // start request repeated while busy and every wait but the one in STEP_WAIT_STOP held for a tick
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b1);
    push_tick(1'b1, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);
    // default settle wait runs out on planned ticks
    queue_sequences(0);
    wait_drained();

    // register extremes: start on the switch, zero settle wait, full speed
    write_reg(REG_APPROACH_SPEED, 16'hFFFF);
    write_reg(REG_SETTLE_TICKS, 16'h0000);
    push_tick(1'b1, 1'b1, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    queue_sequences(250);
    wait_drained();

    // now the other way round: sender idles a lot, receiver rarely
    send_idle_pct = 68;
    recv_idle_pct = 9;

    // zero speed, one-tick settle; unknown indexes must not touch either register
    write_reg(REG_APPROACH_SPEED, 16'h0000);
    write_reg(REG_SETTLE_TICKS, 16'h0001);
    write_reg(8'd2, 16'h1234);
    write_reg(8'hFF, 16'hFFFF);
    queue_sequences(250);
    wait_drained();

    write_reg(REG_APPROACH_SPEED, 16'($urandom_range(65535)));
    write_reg(REG_SETTLE_TICKS, 16'($urandom_range(20, 2)));
    queue_sequences(250);
    wait_drained();

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;

    write_reg(REG_APPROACH_SPEED, 16'($urandom_range(65535)));
    write_reg(REG_SETTLE_TICKS, 16'($urandom_range(7)));
    queue_sequences(250);
    wait_drained();

    repeat (8) @(posedge clk);
    $display("covered %0d ticks and %0d result beats, %0d encoder clears",
             ticks_taken, results_checked, clears_seen);
    $display("register writes: %0d, settle waits from zero up to the reset value",
             reg_writes);
    if (fail_count == 0) begin
      $display("axis_homing_sequencer: match");
    end else begin
      $display("axis_homing_sequencer: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/ahs_pkg.sv
hdl/ahs_core.sv
hdl/axis_homing_sequencer.sv
hdl/ahs_checker.sv
bench/axis_homing_sequencer_tb.sv
